// ----- src/ray_obb_slab_intersect_unit_macros.svh -----
// Assertion helpers used by the checker of the ray/box unit.
`ifndef RAY_OBB_SLAB_INTERSECT_UNIT_MACROS_SVH
`define RAY_OBB_SLAB_INTERSECT_UNIT_MACROS_SVH

// Overlapping implication, checked at every rising edge outside reset.
`define ROSI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray/box unit check failed");

// Non-overlapping implication, checked at every rising edge outside reset.
`define ROSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray/box unit check failed");

`endif

// ----- src/rosi_pkg.sv -----
// ---------------------------------------------------------------------------
// rosi_pkg
// Types and constants of the ray versus oriented-box slab test unit.
// ---------------------------------------------------------------------------
package rosi_pkg;

  // Working widths of the fixed-point datapath.
  localparam int NUM_W  = 56;  // slab numerator e +/- h, signed Q.32
  localparam int DEN_W  = 54;  // slab denominator f, signed Q.32
  localparam int AX_W   = 34;  // rotated axis component, Q2.30
  localparam int N_W    = 20;  // rotated axis component, Q.16
  localparam int P_W    = 33;  // center minus origin
  localparam int Q_W    = 31;  // quotient magnitude bits
  localparam int DIV_LAT = Q_W + 3;        // abs, setup, one bit per stage, sign
  localparam int LATENCY = 5 + DIV_LAT + 3; // start to done, in cycles

  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } rosi_reg_t;

  // Per-item control that travels beside the dividers.
  typedef struct packed {
    logic       vld;
    logic [2:0] par;
    logic       pmiss;
  } rosi_side_t;

endpackage

// ----- src/rosi_div.sv -----
// ---------------------------------------------------------------------------
// rosi_div
// Pipelined signed divider: Q.32 over Q.32 to Q16.16, truncated, saturated.
// ---------------------------------------------------------------------------
module rosi_div import rosi_pkg::*; (
  input  logic                    clk,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic signed [31:0]      quo
);

  logic [NUM_W-1:0] ua;
  logic [DEN_W-1:0] da;
  logic             nega;

  logic [DEN_W-1:0] r_s   [0:Q_W];
  logic [DEN_W-1:0] d_s   [0:Q_W];
  logic [Q_W-1:0]   low_s [0:Q_W];
  logic [Q_W-1:0]   q_s   [0:Q_W];
  logic             neg_s [0:Q_W];
  logic             sat_s [0:Q_W];

  // Sign and magnitude split.
  always_ff @(posedge clk) begin
    ua   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    da   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    nega <= num[NUM_W-1] ^ den[DEN_W-1];
  end

  // The integer part must stay below 2^15, otherwise the result saturates.
  always_ff @(posedge clk) begin
    sat_s[0] <= (ua >> 15) >= NUM_W'(da);
    r_s[0]   <= DEN_W'(ua >> 15);
    low_s[0] <= {ua[14:0], 16'b0};
    q_s[0]   <= '0;
    d_s[0]   <= da;
    neg_s[0] <= nega;
  end

  // One restoring step per stage.
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0] rs;
    logic           ge;
    assign rs = {r_s[k], low_s[k][Q_W-1]};
    assign ge = rs >= {1'b0, d_s[k]};
    always_ff @(posedge clk) begin
      r_s[k+1]   <= ge ? DEN_W'(rs - {1'b0, d_s[k]}) : DEN_W'(rs);
      low_s[k+1] <= {low_s[k][Q_W-2:0], 1'b0};
      q_s[k+1]   <= {q_s[k][Q_W-2:0], ge};
      d_s[k+1]   <= d_s[k];
      neg_s[k+1] <= neg_s[k];
      sat_s[k+1] <= sat_s[k];
    end
  end

  // Apply sign and saturation.
  always_ff @(posedge clk) begin
    if (sat_s[Q_W]) begin
      quo <= neg_s[Q_W] ? T_MIN : T_MAX;
    end else if (neg_s[Q_W]) begin
      quo <= -$signed({1'b0, q_s[Q_W]});
    end else begin
      quo <= $signed({1'b0, q_s[Q_W]});
    end
  end

endmodule

// ----- src/ray_obb_slab_intersect_unit.sv -----
// ---------------------------------------------------------------------------
// ray_obb_slab_intersect_unit
// Tests the configured ray against one oriented bounding box per transaction.
// ---------------------------------------------------------------------------
//  channel   signals                              handshake
//  input     center_*, quat_*, extent_*           start && !busy
//  result    hit, distance                        done, one cycle
//  config    cfg_addr, cfg_data                   cfg_we
//
// A box enters every cycle; busy stays low. Each box runs through the front
// stages, six dividers of 31 restoring stages each, and the back stages.
// Reset clears all valid bits and loads the ray registers.
// The receiver cannot stall; no stall state exists in the pipeline.
module ray_obb_slab_intersect_unit import rosi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic [30:0]        extent_x,
  input  logic [30:0]        extent_y,
  input  logic [30:0]        extent_z,
  output logic               done,
  output logic               hit,
  output logic [30:0]        distance,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] org [0:2];
  logic signed [31:0] dir [0:2];

  logic               v1, v2, v3, v4, v5;
  logic signed [P_W-1:0]  p1 [0:2], p2 [0:2];
  logic signed [31:0]     pr1 [0:8];
  logic [30:0]            h1 [0:2], h2 [0:2], h3 [0:2], h4 [0:2];
  logic signed [N_W-1:0]  n2 [0:8];
  logic signed [NUM_W-1:0] mp3 [0:8];
  logic signed [DEN_W-1:0] md3 [0:8];
  logic signed [NUM_W-1:0] e4 [0:2];
  logic signed [DEN_W-1:0] f4 [0:2];
  logic signed [NUM_W-1:0] na5 [0:2], nb5 [0:2];
  logic signed [DEN_W-1:0] d5 [0:2];
  logic [2:0]             par5;
  logic                   pmiss5;
  rosi_side_t             side5;
  rosi_side_t             side_d [0:DIV_LAT-1];
  logic signed [31:0]     ta [0:2], tb [0:2];
  logic signed [31:0]     lo6 [0:2], hi6 [0:2];
  logic                   v6, miss6, v7, miss7;
  logic signed [31:0]     tmin7, tmax7;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= 32'sd65536;
    end else if (cfg_we) begin
      case (rosi_reg_t'(cfg_addr))
        REG_ORIGIN_X: org[0] <= cfg_data;
        REG_ORIGIN_Y: org[1] <= cfg_data;
        REG_ORIGIN_Z: org[2] <= cfg_data;
        REG_DIR_X:    dir[0] <= cfg_data;
        REG_DIR_Y:    dir[1] <= cfg_data;
        REG_DIR_Z:    dir[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1: center relative to the ray origin and quaternion products.
  always_ff @(posedge clk) begin
    p1[0]  <= P_W'(center_x) - P_W'(org[0]);
    p1[1]  <= P_W'(center_y) - P_W'(org[1]);
    p1[2]  <= P_W'(center_z) - P_W'(org[2]);
    pr1[0] <= quat_x * quat_x;
    pr1[1] <= quat_y * quat_y;
    pr1[2] <= quat_z * quat_z;
    pr1[3] <= quat_x * quat_y;
    pr1[4] <= quat_x * quat_z;
    pr1[5] <= quat_y * quat_z;
    pr1[6] <= quat_w * quat_x;
    pr1[7] <= quat_w * quat_y;
    pr1[8] <= quat_w * quat_z;
    h1[0]  <= extent_x;
    h1[1]  <= extent_y;
    h1[2]  <= extent_z;
  end

  // Stage 2: rotated box axes in Q2.30, floored to Q.16.
  always_ff @(posedge clk) begin
    logic signed [AX_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
    logic signed [AX_W-1:0] ax [0:8];
    xx  = AX_W'(pr1[0]);
    yy  = AX_W'(pr1[1]);
    zz  = AX_W'(pr1[2]);
    xy  = AX_W'(pr1[3]);
    xz  = AX_W'(pr1[4]);
    yz  = AX_W'(pr1[5]);
    wx  = AX_W'(pr1[6]);
    wy  = AX_W'(pr1[7]);
    wz  = AX_W'(pr1[8]);
    one = AX_W'(34'sd1073741824);
    ax[0] = one - ((yy + zz) <<< 1);
    ax[1] = (xy + wz) <<< 1;
    ax[2] = (xz - wy) <<< 1;
    ax[3] = (xy - wz) <<< 1;
    ax[4] = one - ((xx + zz) <<< 1);
    ax[5] = (yz + wx) <<< 1;
    ax[6] = (xz + wy) <<< 1;
    ax[7] = (yz - wx) <<< 1;
    ax[8] = one - ((xx + yy) <<< 1);
    for (int k = 0; k < 9; k++) begin
      n2[k] <= ax[k][AX_W-1:14];
    end
    for (int k = 0; k < 3; k++) begin
      p2[k] <= p1[k];
      h2[k] <= h1[k];
    end
  end

  // Stage 3: axis times offset and axis times direction.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      mp3[k] <= NUM_W'(n2[k] * p2[k % 3]);
      md3[k] <= DEN_W'(n2[k] * dir[k % 3]);
    end
    for (int k = 0; k < 3; k++) begin
      h3[k] <= h2[k];
    end
  end

  // Stage 4: dot products e and f per axis.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e4[i] <= mp3[3*i] + mp3[3*i+1] + mp3[3*i+2];
      f4[i] <= md3[3*i] + md3[3*i+1] + md3[3*i+2];
      h4[i] <= h3[i];
    end
  end

  // Stage 5: slab numerators and the parallel slab test.
  always_ff @(posedge clk) begin
    logic signed [NUM_W-1:0] hq, ep, em;
    logic                    pm;
    pm = 1'b0;
    for (int i = 0; i < 3; i++) begin
      hq = NUM_W'({h4[i], 16'b0});
      ep = e4[i] + hq;
      em = e4[i] - hq;
      na5[i] <= ep;
      nb5[i] <= em;
      d5[i]  <= f4[i];
      par5[i] <= (f4[i] == '0);
      if ((f4[i] == '0) && (ep < 0 || em > 0)) begin
        pm = 1'b1;
      end
    end
    pmiss5 <= pm;
  end

  assign side5 = '{vld: v5, par: par5, pmiss: pmiss5};

  // Slab distances, two per axis.
  for (genvar i = 0; i < 3; i++) begin : g_axis
    rosi_div u_div_a (.clk(clk), .num(na5[i]), .den(d5[i]), .quo(ta[i]));
    rosi_div u_div_b (.clk(clk), .num(nb5[i]), .den(d5[i]), .quo(tb[i]));
  end

  // Control travelling beside the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        side_d[k] <= '0;
      end
    end else begin
      side_d[0] <= side5;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  // Stage 6: order each slab's entry and exit.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (side_d[DIV_LAT-1].par[i]) begin
        lo6[i] <= T_MIN;
        hi6[i] <= T_MAX;
      end else if (ta[i] < tb[i]) begin
        lo6[i] <= ta[i];
        hi6[i] <= tb[i];
      end else begin
        lo6[i] <= tb[i];
        hi6[i] <= ta[i];
      end
    end
    miss6 <= side_d[DIV_LAT-1].pmiss;
  end

  // Stage 7: latest entry and earliest exit.
  always_ff @(posedge clk) begin
    logic signed [31:0] mn, mx;
    mn = lo6[0];
    mx = hi6[0];
    for (int i = 1; i < 3; i++) begin
      if (lo6[i] > mn) mn = lo6[i];
      if (hi6[i] < mx) mx = hi6[i];
    end
    tmin7 <= mn;
    tmax7 <= mx;
    miss7 <= miss6;
  end

  // Result register.
  always_ff @(posedge clk) begin
    logic ok;
    ok = !miss7 && !(tmin7 > tmax7) && !(tmax7 < 0);
    hit <= ok;
    if (!ok) begin
      distance <= '0;
    end else if (tmin7 > 0) begin
      distance <= tmin7[30:0];
    end else begin
      distance <= tmax7[30:0];
    end
  end

  // Valid bits of the back stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v6   <= 1'b0;
      v7   <= 1'b0;
      done <= 1'b0;
    end else begin
      v6   <= side_d[DIV_LAT-1].vld;
      v7   <= v6;
      done <= v7;
    end
  end

endmodule

// ----- src/rosi_checker.sv -----
// ---------------------------------------------------------------------------
// rosi_checker
// Port-level checks of the ray/box unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "ray_obb_slab_intersect_unit_macros.svh"

module rosi_checker import rosi_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        hit,
  input logic [30:0] distance
);

  // Every result stems from an earlier accepted transaction.
  `ROSI_ASSERT_IMPLY(a_done_has_source, clk, rst, done, $past(start && !busy, LATENCY))
  // Every accepted transaction is followed by a result.
  `ROSI_ASSERT_IMPLY(a_start_gives_done, clk, rst, start && !busy, ##LATENCY done)
  // A miss reports a zero distance.
  `ROSI_ASSERT_IMPLY(a_miss_zero, clk, rst, done && !hit, distance == '0)
  // Reset leaves no result behind.
  `ROSI_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !done)

endmodule

bind ray_obb_slab_intersect_unit rosi_checker u_rosi_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .hit(hit),
  .distance(distance)
);
